// File: rtl/calclk_pkg.sv
`default_nettype none
package calclk_pkg;

   localparam logic [2:0] CMD_TICK       = 3'd0;
   localparam logic [2:0] CMD_ADD_DAYS   = 3'd1;
   localparam logic [2:0] CMD_ADD_MONTHS = 3'd2;
   localparam logic [2:0] CMD_ADD_YEARS  = 3'd3;
   localparam logic [2:0] CMD_SET_TIME   = 3'd4;
   localparam logic [2:0] CMD_SET_DATE   = 3'd5;

   localparam logic [13:0] YEAR_MAX   = 14'd9999;
   localparam logic [13:0] YEAR_RESET = 14'd2000;
   localparam logic [3:0]  MONTH_MAX  = 4'd12;

   // reciprocals: (x * RECIP_12) >> 19 is x / 12 for x < 2**16,
   // (y * RECIP_25) >> 17 is y / 25 for y < 2**14
   localparam logic [15:0] RECIP_12 = 16'd43691;
   localparam logic [12:0] RECIP_25 = 13'd5243;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // days in the year before the first of month m
   function automatic logic [8:0] days_before(input logic [3:0] m, input logic leap);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         default: d = 9'd334;
      endcase
      if (leap && m > 4'd2) d = d + 9'd1;
      return d;
   endfunction

endpackage
`default_nettype wire

// File: rtl/calendar_clock.sv
// Gregorian real-time clock and calendar.
// The req_ channel carries one command item: tick, add days, add months,
// add years, set time or set date, with its operands. Every accepted item
// yields exactly one rsp_ item holding the time and date after the command
// and an error flag for a rejected command, a failed day carry or a
// saturated year.
// Commands run one at a time on a small sequencer around one shared
// compare-and-subtract unit; req_stall is high while a command is in work.
// After acceptance a tick or set time without day carry goes straight to
// S_DONE; add years runs S_LEAP1 and S_LEAP2 before S_DONE, set date adds
// S_CLAMP after them, and add months runs S_MDIV and S_MREM first. A day
// walk (add days, or a carry out of the hour) runs S_DPREP, then S_YEAR,
// S_LEAP1 and S_LEAP2 per whole year crossed, S_MONTH, then S_DONE.
// The result sits in an output register, so a new item is accepted while
// an earlier result still waits; a command that finishes while the
// receiver stalls holds in its last step until that register frees.
// Reset gives 00:00:00 on 1 February 2000 with no result pending.
`default_nettype none
module calendar_clock (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_command,
   input  wire logic signed [15:0] req_amount,
   input  wire logic [4:0]  req_new_hour,
   input  wire logic [5:0]  req_new_minute,
   input  wire logic [5:0]  req_new_second,
   input  wire logic [4:0]  req_new_day,
   input  wire logic [3:0]  req_new_month,
   input  wire logic [13:0] req_new_year,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [5:0]       rsp_out_second,
   output logic [5:0]       rsp_out_minute,
   output logic [4:0]       rsp_out_hour,
   output logic [4:0]       rsp_out_day,
   output logic [3:0]       rsp_out_month,
   output logic [13:0]      rsp_out_year,
   output logic             rsp_error_flag
);
   import calclk_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DPREP, S_YEAR, S_MONTH, S_MDIV, S_MREM,
      S_LEAP1, S_LEAP2, S_CLAMP, S_DONE
   } state_type;

   state_type   state_ff, state_in, ret_ff, ret_in;
   logic [5:0]  sec_ff, sec_in, min_ff, min_in;
   logic [4:0]  hour_ff, hour_in, day_ff, day_in;
   logic [3:0]  month_ff, month_in, mon_ff, mon_in;
   logic [13:0] year_ff, year_in;
   logic        leap_ff, leap_in, err_ff, err_in;
   logic [15:0] td_ff, td_in;
   logic [12:0] quot_ff, quot_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [5:0]  osec_ff, osec_in, omin_ff, omin_in;
   logic [4:0]  ohour_ff, ohour_in, oday_ff, oday_in;
   logic [3:0]  omonth_ff, omonth_in;
   logic [13:0] oyear_ff, oyear_in;
   logic        oerr_ff, oerr_in;

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_second = osec_ff;
   assign rsp_out_minute = omin_ff;
   assign rsp_out_hour   = ohour_ff;
   assign rsp_out_day    = oday_ff;
   assign rsp_out_month  = omonth_ff;
   assign rsp_out_year   = oyear_ff;
   assign rsp_error_flag = oerr_ff;

   always_comb begin
      logic [6:0]  s_t, mi_t;
      logic [5:0]  h_t;
      logic        carry;
      logic [15:0] limit;
      logic [4:0]  len;
      logic [31:0] prod12;
      logic [26:0] prod25;
      logic [15:0] rem12;
      logic [14:0] ysum;
      logic signed [16:0] ysig;
      logic [13:0] r25;
      logic [4:0]  nd;
      logic        date_ok;

      state_in     = state_ff;
      ret_in       = ret_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      mon_in       = mon_ff;
      year_in      = year_ff;
      leap_in      = leap_ff;
      err_in       = err_ff;
      td_in        = td_ff;
      quot_in      = quot_ff;
      rsp_valid_in = rsp_valid_ff;
      osec_in      = osec_ff;
      omin_in      = omin_ff;
      ohour_in     = ohour_ff;
      oday_in      = oday_ff;
      omonth_in    = omonth_ff;
      oyear_in     = oyear_ff;
      oerr_in      = oerr_ff;

      s_t     = 7'd0;
      mi_t    = 7'd0;
      h_t     = 6'd0;
      carry   = 1'b0;
      limit   = 16'd0;
      len     = month_len(month_ff, leap_ff);
      prod12  = td_ff * {16'd0, RECIP_12};
      prod25  = year_ff * {1'b0, RECIP_25};
      rem12   = td_ff - ({3'd0, quot_ff} * 16'd12);
      ysum    = {1'b0, year_ff} + {2'd0, quot_ff};
      ysig    = $signed({3'b000, year_ff}) + $signed({req_amount[15], req_amount});
      r25     = year_ff - ({4'd0, quot_ff[9:0]} * 14'd25);
      nd      = td_ff[4:0];
      date_ok = (day_ff != 5'd0) && (month_ff != 4'd0) && (month_ff <= MONTH_MAX) &&
                (day_ff <= len);

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               err_in = 1'b0;
               case (req_command)
                  CMD_TICK: begin
                     s_t  = {1'b0, sec_ff} + 7'd1;
                     mi_t = {1'b0, min_ff};
                     h_t  = {1'b0, hour_ff};
                     if (s_t >= 7'd60) begin
                        s_t  = 7'd0;
                        mi_t = mi_t + 7'd1;
                        if (mi_t >= 7'd60) begin
                           mi_t = 7'd0;
                           h_t  = h_t + 6'd1;
                           if (h_t >= 6'd24) begin
                              h_t   = 6'd0;
                              carry = 1'b1;
                           end
                        end
                     end
                     sec_in   = s_t[5:0];
                     min_in   = mi_t[5:0];
                     hour_in  = h_t[4:0];
                     td_in    = 16'd1;
                     state_in = carry ? S_DPREP : S_DONE;
                  end
                  CMD_ADD_DAYS: begin
                     td_in    = req_amount;
                     state_in = S_DPREP;
                  end
                  CMD_ADD_MONTHS: begin
                     if (req_amount[15] || req_amount == 16'sd0) begin
                        err_in   = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        td_in    = {12'd0, month_ff - 4'd1} + {1'b0, req_amount[14:0]};
                        state_in = S_MDIV;
                     end
                  end
                  CMD_ADD_YEARS: begin
                     if (ysig < 17'sd0) begin
                        year_in = 14'd0;
                        err_in  = 1'b1;
                     end else if (ysig > $signed({3'b000, YEAR_MAX})) begin
                        year_in = YEAR_MAX;
                        err_in  = 1'b1;
                     end else begin
                        year_in = ysig[13:0];
                     end
                     ret_in   = S_DONE;
                     state_in = S_LEAP1;
                  end
                  CMD_SET_TIME: begin
                     h_t  = {1'b0, req_new_hour};
                     mi_t = {1'b0, req_new_minute};
                     s_t  = {1'b0, req_new_second};
                     if (h_t >= 6'd24) begin
                        h_t   = h_t - 6'd24;
                        carry = 1'b1;
                     end
                     if (mi_t >= 7'd60) begin
                        mi_t = mi_t - 7'd60;
                        h_t  = h_t + 6'd1;
                        if (h_t >= 6'd24) begin
                           h_t   = 6'd0;
                           carry = 1'b1;
                        end
                     end
                     if (s_t >= 7'd60) begin
                        s_t  = s_t - 7'd60;
                        mi_t = mi_t + 7'd1;
                        if (mi_t >= 7'd60) begin
                           mi_t = 7'd0;
                           h_t  = h_t + 6'd1;
                           if (h_t >= 6'd24) begin
                              h_t   = 6'd0;
                              carry = 1'b1;
                           end
                        end
                     end
                     sec_in   = s_t[5:0];
                     min_in   = mi_t[5:0];
                     hour_in  = h_t[4:0];
                     td_in    = 16'd1;
                     state_in = carry ? S_DPREP : S_DONE;
                  end
                  CMD_SET_DATE: begin
                     if (req_new_year > YEAR_MAX) begin
                        year_in = YEAR_MAX;
                        err_in  = 1'b1;
                     end else begin
                        year_in = req_new_year;
                     end
                     if (req_new_month == 4'd0)          month_in = 4'd1;
                     else if (req_new_month > MONTH_MAX) month_in = MONTH_MAX;
                     else                                month_in = req_new_month;
                     td_in    = {11'd0, req_new_day};
                     ret_in   = S_CLAMP;
                     state_in = S_LEAP1;
                  end
                  default: begin
                     err_in   = 1'b1;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DPREP: begin
            // reject a non-positive count or an invalid stored date
            if (td_ff[15] || td_ff == 16'd0 || !date_ok) begin
               err_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               td_in    = {11'd0, day_ff} + {7'd0, days_before(month_ff, leap_ff)} +
                          {1'b0, td_ff[14:0]};
               state_in = S_YEAR;
            end
         end
         S_YEAR: begin
            limit = leap_ff ? 16'd366 : 16'd365;
            if (td_ff > limit) begin
               td_in = td_ff - limit;
               if (year_ff >= YEAR_MAX) begin
                  year_in  = YEAR_MAX;
                  month_in = MONTH_MAX;
                  day_in   = 5'd31;
                  err_in   = 1'b1;
                  state_in = S_DONE;
               end else begin
                  year_in  = year_ff + 14'd1;
                  ret_in   = S_YEAR;
                  state_in = S_LEAP1;
               end
            end else begin
               mon_in   = 4'd1;
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            limit = {11'd0, month_len(mon_ff, leap_ff)};
            if (mon_ff < MONTH_MAX && td_ff > limit) begin
               td_in  = td_ff - limit;
               mon_in = mon_ff + 4'd1;
            end else begin
               month_in = mon_ff;
               day_in   = td_ff[4:0];
               state_in = S_DONE;
            end
         end
         S_MDIV: begin
            quot_in  = prod12[31:19];
            state_in = S_MREM;
         end
         S_MREM: begin
            month_in = rem12[3:0] + 4'd1;
            if (ysum > {1'b0, YEAR_MAX}) begin
               year_in = YEAR_MAX;
               err_in  = 1'b1;
            end else begin
               year_in = ysum[13:0];
            end
            ret_in   = S_DONE;
            state_in = S_LEAP1;
         end
         S_LEAP1: begin
            quot_in  = {3'd0, prod25[26:17]};
            state_in = S_LEAP2;
         end
         S_LEAP2: begin
            // divisible by 400 is divisible by 16 and by 25
            leap_in  = (year_ff[1:0] == 2'd0) && ((r25 != 14'd0) || (year_ff[3:0] == 4'd0));
            state_in = ret_ff;
         end
         S_CLAMP: begin
            if (nd == 5'd0) nd = 5'd1;
            if (nd > len) nd = len;
            day_in   = nd;
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register frees
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               osec_in      = sec_ff;
               omin_in      = min_ff;
               ohour_in     = hour_ff;
               oday_in      = day_ff;
               omonth_in    = month_ff;
               oyear_in     = year_ff;
               oerr_in      = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_DONE;
         sec_ff       <= 6'd0;
         min_ff       <= 6'd0;
         hour_ff      <= 5'd0;
         day_ff       <= 5'd1;
         month_ff     <= 4'd2;
         year_ff      <= YEAR_RESET;
         leap_ff      <= 1'b1;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         sec_ff       <= sec_in;
         min_ff       <= min_in;
         hour_ff      <= hour_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         leap_ff      <= leap_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mon_ff    <= mon_in;
      td_ff     <= td_in;
      quot_ff   <= quot_in;
      osec_ff   <= osec_in;
      omin_ff   <= omin_in;
      ohour_ff  <= ohour_in;
      oday_ff   <= oday_in;
      omonth_ff <= omonth_in;
      oyear_ff  <= oyear_in;
      oerr_ff   <= oerr_in;
   end

endmodule
`default_nettype wire
